FILE: rtl/lru_pkg.sv
`timescale 1ns / 1ps
package lru_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int ID_W    = 64;
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 3;
	localparam int ENTRY_W = 7;
	localparam int LIM_W   = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;

	localparam logic [ACT_W-1:0] ACT_ACCESS = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
	localparam int ACT_POP_BIT = 1;

	localparam logic [ENTRY_W-1:0] MAX_ENTRIES_RST = ENTRY_W'(64);

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_MOVED     = 3'd1,
		ST_FULL      = 3'd2,
		ST_DELETED   = 3'd3,
		ST_DEL_MISS  = 3'd4,
		ST_POPPED    = 3'd5,
		ST_POP_EMPTY = 3'd6
	} lru_status_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [ID_W-1:0]  file_id;
	} lru_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ID_W-1:0]    popped_id;
		logic [ENTRY_W-1:0] entry_count;
		logic               overflow_flag;
	} lru_result_t;

endpackage

FILE: rtl/lru_id_tracker.sv
`timescale 1ns / 1ps
// A command taken at a clock edge is registered in the s1 stage (valid_s1, action_s1, id_s1);
// its result and the result strobe are then registered in result_q and result_valid_q.
// Throughput: one command per cycle; busy is low from the first edge after reset release.
// Every slot is compared in parallel and the list shifts in the same cycle.
// Reset clears the count, the overflow flag and the limit (back to 64); slots are not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module lru_id_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  lru_pkg::lru_cmd_t           cmd,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lru_pkg::ENTRY_W-1:0] cfg_data,
	output logic                        result_valid,
	output lru_pkg::lru_result_t        result
);
	import lru_pkg::*;

	logic                busy_q;
	logic                valid_s1;
	logic [ACT_W-1:0]    action_s1;
	logic [ID_W-1:0]     id_s1;
	logic [ENTRY_W-1:0]  max_entries_q;
	logic [CNT_W-1:0]    held_q;
	logic                overflow_q;
	logic [ID_W-1:0]     slots_q [DEPTH];
	logic [ID_W-1:0]     slots_d [DEPTH];
	logic                result_valid_q;
	lru_result_t         result_q;

	logic [DEPTH-1:0]    match;
	logic [DEPTH-1:0]    upto;
	logic [DEPTH-1:0]    from;
	logic                hit;
	logic                is_pop;
	logic                is_del;
	logic [LIM_W-1:0]    eff_lim;
	logic                full;
	logic [IDX_W-1:0]    last_idx;
	logic                do_insert;
	logic                do_move;
	logic                do_delete;
	logic [CNT_W-1:0]    held_d;
	logic                overflow_d;
	lru_status_t         status_d;
	logic [ID_W-1:0]     popped_d;

	assign busy      = busy_q;
	assign cfg_ready = !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			action_s1 <= cmd.action;
			id_s1     <= cmd.file_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_entries_q <= cfg_data;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cmp
			assign match[gi] = (CNT_W'(gi) < held_q) && (slots_q[gi] == id_s1);
			assign upto[gi]  = |(match >> gi);
			assign from[gi]  = |(match << (DEPTH - 1 - gi));
		end
	endgenerate

	assign hit      = |match;
	assign is_pop   = action_s1[ACT_POP_BIT];
	assign is_del   = !is_pop && (action_s1 == ACT_DELETE);
	assign last_idx = IDX_W'(held_q - CNT_W'(1));

	always_comb begin
		if (max_entries_q == '0) begin
			eff_lim = LIM_W'(1);
		end else if (LIM_W'(max_entries_q) > LIM_W'(DEPTH)) begin
			eff_lim = LIM_W'(DEPTH);
		end else begin
			eff_lim = LIM_W'(max_entries_q);
		end
	end

	assign full = LIM_W'(held_q) >= eff_lim;

	always_comb begin
		do_insert  = 1'b0;
		do_move    = 1'b0;
		do_delete  = 1'b0;
		held_d     = held_q;
		overflow_d = overflow_q;
		popped_d   = '0;
		priority if (is_pop) begin
			if (held_q == '0) begin
				status_d = ST_POP_EMPTY;
			end else begin
				popped_d   = slots_q[last_idx];
				held_d     = held_q - CNT_W'(1);
				overflow_d = 1'b0;
				status_d   = ST_POPPED;
			end
		end else if (is_del) begin
			if (hit) begin
				do_delete = 1'b1;
				held_d    = held_q - CNT_W'(1);
				status_d  = ST_DELETED;
			end else begin
				status_d = ST_DEL_MISS;
			end
		end else begin
			if (hit) begin
				do_move  = 1'b1;
				status_d = ST_MOVED;
			end else if (full) begin
				overflow_d = 1'b1;
				status_d   = ST_FULL;
			end else begin
				do_insert = 1'b1;
				held_d    = held_q + CNT_W'(1);
				status_d  = ST_INSERTED;
			end
		end
	end

	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_next
			if (gi == 0) begin : g_head
				if (DEPTH > 1) begin : g_multi
					always_comb begin
						if (do_insert || do_move) begin
							slots_d[gi] = id_s1;
						end else if (do_delete && from[gi]) begin
							slots_d[gi] = slots_q[gi+1];
						end else begin
							slots_d[gi] = slots_q[gi];
						end
					end
				end else begin : g_single
					always_comb begin
						if (do_insert || do_move) begin
							slots_d[gi] = id_s1;
						end else begin
							slots_d[gi] = slots_q[gi];
						end
					end
				end
			end else if (gi == DEPTH - 1) begin : g_tail
				always_comb begin
					if (do_insert || (do_move && upto[gi])) begin
						slots_d[gi] = slots_q[gi-1];
					end else begin
						slots_d[gi] = slots_q[gi];
					end
				end
			end else begin : g_mid
				always_comb begin
					if (do_insert || (do_move && upto[gi])) begin
						slots_d[gi] = slots_q[gi-1];
					end else if (do_delete && from[gi]) begin
						slots_d[gi] = slots_q[gi+1];
					end else begin
						slots_d[gi] = slots_q[gi];
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int i = 0; i < DEPTH; i++) begin
				slots_q[i] <= slots_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= '0;
			overflow_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				held_q     <= held_d;
				overflow_q <= overflow_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.status        <= status_d;
			result_q.popped_id     <= popped_d;
			result_q.entry_count   <= ENTRY_W'(held_d);
			result_q.overflow_flag <= overflow_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: rtl/lru_chk.sv
`timescale 1ns / 1ps
module lru_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        result_valid,
	input  lru_pkg::lru_result_t        result
);
	import lru_pkg::*;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 result_valid)
		else $error("transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, 2))
		else $error("result without a transaction");

	a_popped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_POPPED) |-> (result.popped_id == '0))
		else $error("popped_id set without a pop");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_FULL) |-> result.overflow_flag)
		else $error("ignored identifier without overflow flag");

	a_pop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_POPPED) |->
			(!result.overflow_flag && (result.entry_count < ENTRY_W'(DEPTH))))
		else $error("pop left overflow set or count at depth");

endmodule

bind lru_id_tracker lru_chk u_lru_chk (.*);

FILE: dv/lru_id_monitor.sv
`timescale 1ns / 1ps
module lru_id_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  lru_pkg::lru_cmd_t           cmd,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [lru_pkg::ENTRY_W-1:0] cfg_data,
	input  logic                        result_valid,
	input  lru_pkg::lru_result_t        result,
	output int                          errors,
	output int                          pending,
	output int                          checked,
	output logic [6:0]                  status_seen
);
	import lru_pkg::*;

	logic [ID_W-1:0]    lru_ids[DEPTH];
	int                 lru_held;
	logic               lru_overflow;
	logic [ENTRY_W-1:0] max_entries;
	lru_result_t        lru_results_due[$];

	function automatic lru_result_t next_lru_result(input lru_cmd_t c);
		lru_result_t r;
		int          lim;
		int          pos;
		int          i;
		r = '0;
		lim = int'(max_entries);
		if (lim == 0) lim = 1;
		if (lim > DEPTH) lim = DEPTH;
		if (c.action[ACT_POP_BIT]) begin
			if (lru_held == 0) begin
				r.status = ST_POP_EMPTY;
			end else begin
				r.popped_id = lru_ids[lru_held - 1];
				lru_held--;
				lru_overflow = 1'b0;
				r.status = ST_POPPED;
			end
		end else begin
			pos = lru_held;
			for (i = 0; i < lru_held; i++)
				if (pos == lru_held && lru_ids[i] == c.file_id) pos = i;
			if (c.action == ACT_DELETE) begin
				if (pos < lru_held) begin
					for (i = pos; i + 1 < lru_held; i++) lru_ids[i] = lru_ids[i + 1];
					lru_held--;
					r.status = ST_DELETED;
				end else begin
					r.status = ST_DEL_MISS;
				end
			end else if (pos < lru_held) begin
				for (i = pos; i > 0; i--) lru_ids[i] = lru_ids[i - 1];
				lru_ids[0] = c.file_id;
				r.status = ST_MOVED;
			end else if (lru_held >= lim) begin
				lru_overflow = 1'b1;
				r.status = ST_FULL;
			end else begin
				for (i = lru_held; i > 0; i--) lru_ids[i] = lru_ids[i - 1];
				lru_ids[0] = c.file_id;
				lru_held++;
				r.status = ST_INSERTED;
			end
		end
		r.entry_count = ENTRY_W'(lru_held);
		r.overflow_flag = lru_overflow;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lru_result_t want;
		int          fails;
		if (!arst_n) begin
			lru_held = 0;
			lru_overflow = 1'b0;
			max_entries = MAX_ENTRIES_RST;
			lru_results_due.delete();
			errors <= 0;
			pending <= 0;
			checked <= 0;
			status_seen <= '0;
		end else begin
			fails = 0;
			if (result_valid) begin
				if (lru_results_due.size() == 0) begin
					$error("result strobe with no transaction outstanding");
					fails++;
				end else begin
					want = lru_results_due.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, result.status);
						fails++;
					end
					if (result.popped_id !== want.popped_id) begin
						$error("popped_id: expected %h, actual %h",
							want.popped_id, result.popped_id);
						fails++;
					end
					if (result.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, actual %0d",
							want.entry_count, result.entry_count);
						fails++;
					end
					if (result.overflow_flag !== want.overflow_flag) begin
						$error("overflow_flag: expected %0d, actual %0d",
							want.overflow_flag, result.overflow_flag);
						fails++;
					end
					checked <= checked + 1;
				end
			end
			if (cfg_valid && cfg_ready) max_entries = cfg_data;
			if (start && !busy) begin
				want = next_lru_result(cmd);
				status_seen[want.status] <= 1'b1;
				lru_results_due.push_back(want);
			end
			pending <= lru_results_due.size();
			errors <= errors + fails;
		end
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import lru_pkg::*;

	localparam logic [ACT_W-1:0] ACT_POP     = 2'd2;
	localparam logic [ACT_W-1:0] ACT_POP_ALT = 2'd3;
	localparam int N_PHASES = 9;
	localparam int PHASE_ITEMS = 78;
	localparam int POOL_SIZE = 96;
	localparam logic [ID_W-1:0] ID_ONES = '1;
	localparam logic [ID_W-1:0] ID_A = 64'h0123_4567_89AB_CDEF;
	localparam logic [ID_W-1:0] ID_B = 64'hFEDC_BA98_7654_3210;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	lru_cmd_t           cmd;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [ENTRY_W-1:0] cfg_data;
	logic               result_valid;
	lru_result_t        result;

	int          errors;
	int          pending;
	int          checked;
	logic [6:0]  status_seen;
	int          n_sent;
	int          n_limits;
	int          idle_pct;
	logic [ID_W-1:0] id_pool[POOL_SIZE];

	int ph_limit[N_PHASES]  = '{127, 1, 0, 64, 2, 65, 7, 40, 64};
	int ph_idle[N_PHASES]   = '{0, 68, 26, 0, 68, 26, 68, 0, 26};
	int ph_access[N_PHASES] = '{70, 55, 60, 75, 50, 65, 60, 80, 55};

	always #5 clk = ~clk;

	lru_id_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	lru_id_monitor u_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.status_seen(status_seen)
	);

	function automatic lru_cmd_t mk_cmd(input logic [ACT_W-1:0] a, input logic [ID_W-1:0] id);
		lru_cmd_t c;
		c.action = a;
		c.file_id = id;
		return c;
	endfunction

	function automatic logic [ID_W-1:0] rand_id();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return ID_ONES;
		if (r < 5) return '0;
		if (r < 15) return rand_id();
		return id_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic lru_cmd_t rand_cmd(input int acc_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < acc_pct) return mk_cmd(ACT_ACCESS, pick_id());
		if (r < acc_pct + (100 - acc_pct) / 2) return mk_cmd(ACT_DELETE, pick_id());
		return mk_cmd($urandom_range(0, 3) == 0 ? ACT_POP_ALT : ACT_POP, rand_id());
	endfunction

	task automatic issue(input lru_cmd_t c);
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		n_sent++;
	endtask

	task automatic idle_gap();
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= mk_cmd(ACT_W'($urandom), rand_id());
		end
	endtask

	// hold off until every outstanding transaction has returned
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [ENTRY_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_limits++;
	endtask

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		n_sent = 0;
		n_limits = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		issue(mk_cmd(ACT_POP, '0));
		issue(mk_cmd(ACT_POP_ALT, ID_ONES));
		issue(mk_cmd(ACT_DELETE, '0));
		issue(mk_cmd(ACT_ACCESS, '0));
		issue(mk_cmd(ACT_ACCESS, ID_ONES));
		issue(mk_cmd(ACT_ACCESS, '0));
		issue(mk_cmd(ACT_DELETE, ID_ONES));
		issue(mk_cmd(ACT_ACCESS, {32{2'b01}}));
		issue(mk_cmd(ACT_ACCESS, {32{2'b10}}));
		issue(mk_cmd(ACT_ACCESS, {32{2'b01}}));
		issue(mk_cmd(ACT_POP_ALT, ID_ONES));
		issue(mk_cmd(ACT_POP, '0));
		issue(mk_cmd(ACT_POP, '0));
		issue(mk_cmd(ACT_POP, '0));

		write_limit(ENTRY_W'(1));
		issue(mk_cmd(ACT_ACCESS, ID_A));
		issue(mk_cmd(ACT_ACCESS, ID_B));
		issue(mk_cmd(ACT_ACCESS, ID_A));
		issue(mk_cmd(ACT_DELETE, ID_B));
		issue(mk_cmd(ACT_POP, ID_B));
		issue(mk_cmd(ACT_ACCESS, ID_B));
		issue(mk_cmd(ACT_POP_ALT, ID_A));

		for (int j = 0; j < POOL_SIZE; j++) id_pool[j] = rand_id();
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_limit(ENTRY_W'(ph_limit[ph]));
			idle_pct = ph_idle[ph];
			for (int j = 0; j < POOL_SIZE / 2; j++) id_pool[j] = rand_id();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				idle_gap();
				if (i == 40 || $urandom_range(0, 59) == 0) drain();
				issue(rand_cmd(ph_access[ph]));
			end
		end

		drain();
		$display("Sent %0d commands across %0d limit settings; %0d results compared",
			n_sent, n_limits, checked);
		$display("Result codes reached, one bit per code from 6 down to 0: %b", status_seen);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
